FILE: hw/rtl/rpfw_pkg.sv
// Shared constants, types and register codes of the rotated pixel framebuffer writer.
`timescale 1ns / 1ps

package rpfw_pkg;

	localparam int FRAME_BYTES = 32768;
	localparam int MAX_SIDE    = 512;

	localparam int ADDR_W     = $clog2(FRAME_BYTES);
	localparam int SIDE_W     = 10;
	localparam int POS_W      = 9;
	localparam int OUT_ADDR_W = 15;
	localparam int BYTE_W     = 8;
	localparam int ROT_W      = 2;
	localparam int MIR_W      = 2;
	localparam int SEL_W      = 3;
	localparam int BIT_W      = 3;

	localparam int CRD_W    = SIDE_W + 2;
	localparam int SIDE_CAP = (MAX_SIDE < (1 << SIDE_W)) ? MAX_SIDE : (1 << SIDE_W) - 1;
	localparam int RB_W     = $clog2((SIDE_CAP + 7) / 8 + 1);
	localparam int XB_W     = SIDE_W - BIT_W;
	localparam int ROWOFF_W = SIDE_W + RB_W;
	localparam int HRB_W    = SIDE_W + RB_W;
	localparam int PAGE_W   = HRB_W + SEL_W;
	localparam int SUM_W    = PAGE_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SIDE_W;

	localparam logic [BYTE_W-1:0] LEFT_BIT_MASK = 8'h80;

	localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

	localparam logic [MIR_W-1:0] MIR_NONE       = 2'd0;
	localparam logic [MIR_W-1:0] MIR_HORIZONTAL = 2'd1;
	localparam logic [MIR_W-1:0] MIR_VERTICAL   = 2'd2;
	localparam logic [MIR_W-1:0] MIR_BOTH       = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEM_WIDTH         = 3'd0,
		REG_MEM_HEIGHT        = 3'd1,
		REG_ROTATION          = 3'd2,
		REG_MIRROR_MODE       = 3'd3,
		REG_INVERTED_POLARITY = 3'd4,
		REG_IMAGE_SELECT      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SIDE_W-1:0] mem_width;
		logic [SIDE_W-1:0] mem_height;
		logic [ROT_W-1:0]  rotation;
		logic [MIR_W-1:0]  mirror_mode;
		logic              inverted_polarity;
		logic [SEL_W-1:0]  image_select;
	} cfg_t;

	typedef struct packed {
		logic                in_plane;
		logic [XB_W-1:0]     xb;
		logic [ROWOFF_W-1:0] row_off;
		logic [PAGE_W-1:0]   page_off;
		logic [BIT_W-1:0]    bit_sel;
		logic                set_bit;
	} s2_item_t;

endpackage

FILE: hw/rtl/rpfw_if.sv
// Valid/ready channel interfaces for pixel items and write results.
`timescale 1ns / 1ps

interface rpfw_pixel_if;
	import rpfw_pkg::*;

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic             is_white;

	modport source (output valid, output pos_x, output pos_y, output is_white, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input is_white, output ready);
endinterface

interface rpfw_result_if;
	import rpfw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OUT_ADDR_W-1:0] byte_address;
	logic [BYTE_W-1:0]     new_byte;
	logic                  dropped;

	modport source (output valid, output byte_address, output new_byte, output dropped,
		input ready);
	modport sink   (input valid, input byte_address, input new_byte, input dropped,
		output ready);
endinterface

FILE: hw/rtl/rpfw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module rpfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/rpfw_addr_gen.sv
// Coordinate mapping and address term generation (stages s1 and s2).
`timescale 1ns / 1ps

module rpfw_addr_gen (
	input  logic               clk,
	input  logic               arst_n,
	rpfw_pixel_if.sink         pix,
	input  rpfw_pkg::cfg_t     cfg,
	input  logic               clr_busy,
	input  logic               take,
	output logic               item_valid,
	output rpfw_pkg::s2_item_t item
);
	import rpfw_pkg::*;

	logic [SIDE_W-1:0] w_eff;
	logic [SIDE_W-1:0] h_eff;
	logic [CRD_W-1:0]  w_ext;
	logic [CRD_W-1:0]  h_ext;
	logic [CRD_W-1:0]  wm1;
	logic [CRD_W-1:0]  hm1;
	logic [CRD_W-1:0]  px;
	logic [CRD_W-1:0]  py;
	logic [CRD_W-1:0]  xr;
	logic [CRD_W-1:0]  yr;
	logic [CRD_W-1:0]  xm;
	logic [CRD_W-1:0]  ym;
	logic [SIDE_W:0]   rb_sum;
	logic [RB_W-1:0]   rb;
	logic              adv1;

	logic              v_s1;
	logic [CRD_W-1:0]  x_s1;
	logic [CRD_W-1:0]  y_s1;
	logic              white_s1;
	logic [HRB_W-1:0]  hrb_s1;
	logic              v_s2;
	s2_item_t          item_s2;

	assign w_eff = (int'(cfg.mem_width) > MAX_SIDE) ? SIDE_W'(SIDE_CAP) : cfg.mem_width;
	assign h_eff = (int'(cfg.mem_height) > MAX_SIDE) ? SIDE_W'(SIDE_CAP) : cfg.mem_height;
	assign w_ext = CRD_W'(w_eff);
	assign h_ext = CRD_W'(h_eff);
	assign wm1   = w_ext - CRD_W'(1);
	assign hm1   = h_ext - CRD_W'(1);
	assign px    = CRD_W'(pix.pos_x);
	assign py    = CRD_W'(pix.pos_y);

	assign rb_sum = (SIDE_W + 1)'(w_eff) + (SIDE_W + 1)'(7);
	assign rb     = RB_W'(rb_sum >> 3);

	always_comb begin
		case (cfg.rotation)
			2'd0: begin
				xr = px;
				yr = py;
			end
			2'd1: begin
				xr = py;
				yr = hm1 - px;
			end
			2'd2: begin
				xr = wm1 - px;
				yr = hm1 - py;
			end
			default: begin
				xr = wm1 - py;
				yr = px;
			end
		endcase
		xm = cfg.mirror_mode[0] ? (wm1 - xr) : xr;
		ym = cfg.mirror_mode[1] ? (hm1 - yr) : yr;
	end

	assign adv1      = v_s1 && (!v_s2 || take);
	assign pix.ready = !clr_busy && (!v_s1 || adv1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (pix.valid && pix.ready) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (take) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			x_s1     <= xm;
			y_s1     <= ym;
			white_s1 <= pix.is_white;
			hrb_s1   <= HRB_W'(h_eff) * HRB_W'(rb);
		end
		if (adv1) begin
			item_s2.in_plane <= !x_s1[CRD_W-1] && !y_s1[CRD_W-1]
				&& (x_s1 < w_ext) && (y_s1 < h_ext);
			item_s2.xb       <= x_s1[SIDE_W-1:BIT_W];
			item_s2.row_off  <= ROWOFF_W'(y_s1[SIDE_W-1:0]) * ROWOFF_W'(rb);
			item_s2.page_off <= PAGE_W'(cfg.image_select) * PAGE_W'(hrb_s1);
			item_s2.bit_sel  <= x_s1[BIT_W-1:0];
			item_s2.set_bit  <= (white_s1 == cfg.inverted_polarity);
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;

endmodule

FILE: hw/rtl/rpfw_rmw.sv
// Byte read-modify-write on the frame store, clear pass and result register.
`timescale 1ns / 1ps

module rpfw_rmw (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  rpfw_pkg::s2_item_t item,
	output logic               take,
	output logic               clr_busy,
	rpfw_result_if.source      res
);
	import rpfw_pkg::*;

	logic [SUM_W-1:0]      sum;
	logic                  out_free;
	logic                  adv3;
	logic [BYTE_W-1:0]     rd_data;
	logic [BYTE_W-1:0]     cur_byte;
	logic [BYTE_W-1:0]     upd_byte;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [BYTE_W-1:0]     ram_wdata;

	logic                  v_s3;
	logic [ADDR_W-1:0]     addr_s3;
	logic                  ok_s3;
	logic [BYTE_W-1:0]     mask_s3;
	logic                  set_s3;

	logic                  clr_busy_q;
	logic [ADDR_W-1:0]     clr_cnt_q;
	logic                  fwd_v_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	logic [BYTE_W-1:0]     fwd_data_q;
	logic                  out_v_q;
	logic [OUT_ADDR_W-1:0] out_addr_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_drop_q;

	assign sum = SUM_W'(item.xb) + SUM_W'(item.row_off) + SUM_W'(item.page_off);

	assign out_free = !out_v_q || res.ready;
	assign adv3     = v_s3 && out_free;
	assign take     = item_valid && (!v_s3 || adv3);
	assign clr_busy = clr_busy_q;

	assign cur_byte = (fwd_v_q && (fwd_addr_q == addr_s3)) ? fwd_data_q : rd_data;
	assign upd_byte = set_s3 ? (cur_byte | mask_s3) : (cur_byte & ~mask_s3);

	assign ram_we    = clr_busy_q || (adv3 && ok_s3);
	assign ram_waddr = clr_busy_q ? clr_cnt_q : addr_s3;
	assign ram_wdata = clr_busy_q ? '0 : upd_byte;

	rpfw_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FRAME_BYTES)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (take),
		.raddr (sum[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3       <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			fwd_v_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (take) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
				if (clr_cnt_q == ADDR_W'(FRAME_BYTES - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (adv3 && ok_s3) begin
				fwd_v_q <= 1'b1;
			end
			if (adv3) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_s3 <= sum[ADDR_W-1:0];
			ok_s3   <= item.in_plane && (sum < SUM_W'(FRAME_BYTES));
			mask_s3 <= LEFT_BIT_MASK >> item.bit_sel;
			set_s3  <= item.set_bit;
		end
		if (adv3 && ok_s3) begin
			fwd_addr_q <= addr_s3;
			fwd_data_q <= upd_byte;
		end
		if (adv3) begin
			out_addr_q <= ok_s3 ? OUT_ADDR_W'(addr_s3) : '0;
			out_byte_q <= ok_s3 ? upd_byte : '0;
			out_drop_q <= !ok_s3;
		end
	end

	assign res.valid        = out_v_q;
	assign res.byte_address = out_addr_q;
	assign res.new_byte     = out_byte_q;
	assign res.dropped      = out_drop_q;

endmodule

FILE: hw/rtl/rotated_pixel_framebuffer_writer_top.sv
// Top level of the rotated pixel framebuffer writer: registers, pipeline and frame store.
//
//   channel  dir  handshake           payload
//   pix      in   valid/ready         pos_x[9], pos_y[9], is_white
//   res      out  valid/ready         byte_address[15], new_byte[8], dropped
//   config   in   wr_en (no ready)    wr_index[3], wr_data[10]
//
// An accepted item passes through stages s1, s2 and s3 to its result in the output register.
// One item per cycle while results are taken; the frame store's single read
// and write port set that figure, a same-byte write is forwarded to the next read.
// After reset a clear pass zeroes all FRAME_BYTES (32768) bytes of the store, with pix held off.
// A stalled result holds the pipeline back stage by stage; config is taken at any time.
`timescale 1ns / 1ps

module rotated_pixel_framebuffer_writer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	rpfw_pixel_if.sink                      pix,
	rpfw_result_if.source                   res,
	input  logic                            wr_en,
	input  logic [rpfw_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rpfw_pkg::CFG_DATA_W-1:0] wr_data
);
	import rpfw_pkg::*;

	cfg_t     cfg_q;
	logic     clr_busy;
	logic     take;
	logic     item_valid;
	s2_item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mem_width         <= SIDE_W'(200);
			cfg_q.mem_height        <= SIDE_W'(200);
			cfg_q.rotation          <= '0;
			cfg_q.mirror_mode       <= '0;
			cfg_q.inverted_polarity <= 1'b0;
			cfg_q.image_select      <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MEM_WIDTH:         cfg_q.mem_width         <= wr_data[SIDE_W-1:0];
				REG_MEM_HEIGHT:        cfg_q.mem_height        <= wr_data[SIDE_W-1:0];
				REG_ROTATION:          cfg_q.rotation          <= wr_data[ROT_W-1:0];
				REG_MIRROR_MODE:       cfg_q.mirror_mode       <= wr_data[MIR_W-1:0];
				REG_INVERTED_POLARITY: cfg_q.inverted_polarity <= wr_data[0];
				REG_IMAGE_SELECT:      cfg_q.image_select      <= wr_data[SEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rpfw_addr_gen u_addr_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.cfg        (cfg_q),
		.clr_busy   (clr_busy),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	rpfw_rmw u_rmw (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.clr_busy   (clr_busy),
		.res        (res)
	);

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.dropped |-> (res.byte_address == '0) && (res.new_byte == '0))
		else $error("dropped result carries nonzero payload");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !pix.ready && !res.valid && !item_valid)
		else $error("pipeline active during clear pass");

	a_take_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> item_valid && !clr_busy)
		else $error("read issued without an item");

endmodule
